/* src/opsc_pkg.sv */
`timescale 1ns / 1ps

package opsc_pkg;

  localparam int InW = 16;
  localparam int InMax = 2 ** InW - 1;
  localparam int CountW = 13;
  localparam int CountMax = 2 ** CountW - 1;
  localparam int OutTdataW = 16;
  localparam int WordBits = 64;
  localparam int PopW = 7;
  localparam int MaxLimitDefault = 65535;

  function automatic logic [PopW-1:0] popcount64(input logic [WordBits-1:0] w);
    logic [3:0] byte_cnt [8];
    logic [PopW-1:0] total;
    for (int k = 0; k < 8; k++) begin
      byte_cnt[k] = 4'd0;
      for (int b = 0; b < 8; b++) begin
        byte_cnt[k] = byte_cnt[k] + 4'(w[8*k+b]);
      end
    end
    total = '0;
    for (int k = 0; k < 8; k++) begin
      total = total + PopW'(byte_cnt[k]);
    end
    return total;
  endfunction

endpackage

/* src/opsc_alu.sv */
`timescale 1ns / 1ps

module opsc_alu #(
  parameter int LimW = 16,
  parameter int VW   = 17
) (
  input  logic [VW-1:0]   op_a_i,
  input  logic [VW-1:0]   op_b_i,
  input  logic [LimW-1:0] bound_i,
  output logic [VW-1:0]   sum_o,
  output logic            le_o
);

  assign sum_o = op_a_i + op_b_i;
  assign le_o  = (sum_o <= VW'(bound_i));

endmodule

/* src/opsc_bitmap.sv */
`timescale 1ns / 1ps

module opsc_bitmap #(
  parameter int Words = 512,
  parameter int AW    = 9
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [opsc_pkg::WordBits-1:0] wdata_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [opsc_pkg::WordBits-1:0] rdata_o
);

  logic [opsc_pkg::WordBits-1:0] mem [Words];
  logic [opsc_pkg::WordBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/opsc_seq.sv */
`timescale 1ns / 1ps

module opsc_seq #(
  parameter int MaxLimit = opsc_pkg::MaxLimitDefault,
  parameter int LimW     = 16,
  parameter int VW       = 17,
  parameter int AW       = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [opsc_pkg::InW-1:0]      in_limit_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [opsc_pkg::CountW-1:0]   out_count_o,
  output logic                          out_clamp_o,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [opsc_pkg::WordBits-1:0] mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [opsc_pkg::WordBits-1:0] mem_rdata_i,
  output logic [VW-1:0]                 alu_a_o,
  output logic [VW-1:0]                 alu_b_o,
  output logic [LimW-1:0]               alu_bound_o,
  input  logic [VW-1:0]                 alu_sum_i,
  input  logic                          alu_le_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_OUTER,
    S_OCHK,
    S_MRD,
    S_MWR,
    S_NXA,
    S_NXB,
    S_CRD,
    S_CPOP,
    S_CACC,
    S_DONE
  } state_e;

  state_e                        state_q;
  logic [LimW-1:0]               lim_q;
  logic                          clamp_q;
  logic [VW-1:0]                 i_q;
  logic [VW-1:0]                 isq_q;
  logic [VW-1:0]                 j_q;
  logic [VW-1:0]                 cnt_q;
  logic [AW-1:0]                 cw_q;
  logic [opsc_pkg::PopW-1:0]     pop_q;
  logic                          out_valid_q;
  logic [opsc_pkg::CountW-1:0]   out_count_q;
  logic                          out_clamp_q;

  logic [31:0]                   in_ext;
  logic                          in_clamp;
  logic [LimW-1:0]               in_lim;
  logic [AW-1:0]                 last_w;
  logic [6:0]                    hi_bits;
  logic [opsc_pkg::WordBits-1:0] cnt_mask;
  logic [VW-1:0]                 step;

  assign in_ext   = 32'(in_limit_i);
  assign in_clamp = in_ext > 32'(MaxLimit);
  assign in_lim   = in_clamp ? LimW'(MaxLimit) : LimW'(in_ext);
  assign last_w   = AW'(lim_q >> 7);
  assign hi_bits  = 7'((8'(lim_q[6:0]) + 8'd1) >> 1);
  assign step     = i_q << 1;

  always_comb begin
    for (int b = 0; b < opsc_pkg::WordBits; b++) begin
      cnt_mask[b] = (cw_q != last_w) || (7'(b) < hi_bits);
    end
    if (cw_q == '0) begin
      cnt_mask[0] = 1'b0;
    end
  end

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = cw_q;
    mem_wdata_o = '0;
    mem_raddr_o = cw_q;
    alu_a_o     = isq_q;
    alu_b_o     = '0;
    case (state_q)
      S_CLEAR: begin
        mem_we_o = 1'b1;
      end
      S_OUTER: begin
        mem_raddr_o = i_q[AW+6:7];
      end
      S_MRD: begin
        mem_raddr_o = j_q[AW+6:7];
      end
      S_MWR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = j_q[AW+6:7];
        mem_wdata_o = mem_rdata_i | (opsc_pkg::WordBits'(1) << j_q[6:1]);
        alu_a_o     = j_q;
        alu_b_o     = step;
      end
      S_NXA, S_NXB: begin
        alu_b_o = step;
      end
      S_CACC: begin
        alu_a_o = cnt_q;
        alu_b_o = VW'(pop_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lim_q       <= '0;
      clamp_q     <= 1'b0;
      i_q         <= '0;
      isq_q       <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      cw_q        <= '0;
      pop_q       <= '0;
      out_valid_q <= 1'b0;
      out_count_q <= '0;
      out_clamp_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            lim_q   <= in_lim;
            clamp_q <= in_clamp;
            cw_q    <= '0;
            if (in_lim < LimW'(2)) begin
              cnt_q   <= '0;
              state_q <= S_DONE;
            end else begin
              cnt_q   <= VW'(1);
              state_q <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (cw_q == last_w) begin
            i_q     <= VW'(3);
            isq_q   <= VW'(9);
            state_q <= S_OUTER;
          end else begin
            cw_q <= cw_q + AW'(1);
          end
        end
        S_OUTER: begin
          if (alu_le_i) begin
            state_q <= S_OCHK;
          end else begin
            cw_q    <= '0;
            state_q <= S_CRD;
          end
        end
        S_OCHK: begin
          if (!mem_rdata_i[i_q[6:1]]) begin
            j_q     <= isq_q;
            state_q <= S_MRD;
          end else begin
            state_q <= S_NXA;
          end
        end
        S_MRD: begin
          state_q <= S_MWR;
        end
        S_MWR: begin
          j_q     <= alu_sum_i;
          state_q <= alu_le_i ? S_MRD : S_NXA;
        end
        S_NXA: begin
          isq_q   <= alu_sum_i;
          i_q     <= i_q + VW'(2);
          state_q <= S_NXB;
        end
        S_NXB: begin
          isq_q   <= alu_sum_i;
          state_q <= S_OUTER;
        end
        S_CRD: begin
          state_q <= S_CPOP;
        end
        S_CPOP: begin
          pop_q   <= opsc_pkg::popcount64(~mem_rdata_i & cnt_mask);
          state_q <= S_CACC;
        end
        S_CACC: begin
          cnt_q <= alu_sum_i;
          if (cw_q == last_w) begin
            state_q <= S_DONE;
          end else begin
            cw_q    <= cw_q + AW'(1);
            state_q <= S_CRD;
          end
        end
        S_DONE: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_clamp_q <= clamp_q;
            if (32'(cnt_q) > 32'(opsc_pkg::CountMax)) begin
              out_count_q <= opsc_pkg::CountW'(opsc_pkg::CountMax);
            end else begin
              out_count_q <= opsc_pkg::CountW'(cnt_q);
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_count_o = out_count_q;
  assign out_clamp_o = out_clamp_q;
  assign alu_bound_o = lim_q;

endmodule

/* src/odd_only_prime_sieve_counter_top.sv */
`timescale 1ns / 1ps

// Channel   Dir  Beat carries
// s_axis    in   tdata[15:0] = upper_limit
// m_axis    out  tdata[12:0] = prime_count, tdata[15:13] = 0; tuser[0] = limit_clamped
//
// For one limit L the sequencer clears the bitmap words in use, tests each odd
// sieving candidate up to sqrt(L), marks each multiple by a read-modify-write
// (a read, then a write on the bitmap's separate read and write ports), and then
// counts the primes word by word.
// The bitmap needs no clearing after reset since each limit of 2 or more clears it first.
// A new limit is accepted while the previous result still waits on the output.

module odd_only_prime_sieve_counter_top #(
  parameter int MaxLimit = opsc_pkg::MaxLimitDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [opsc_pkg::InW-1:0]        s_axis_tdata,   // [15:0] upper_limit
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [opsc_pkg::OutTdataW-1:0]  m_axis_tdata,   // [12:0] prime_count, zero pad
  output logic [0:0]                      m_axis_tuser    // [0] limit_clamped
);

  localparam int EffMax = (MaxLimit < opsc_pkg::InMax) ? MaxLimit : opsc_pkg::InMax;
  localparam int LimW   = $clog2(EffMax + 1);
  localparam int VW     = LimW + 1;
  localparam int Words  = EffMax / 128 + 1;
  localparam int AW     = $clog2(Words);

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [opsc_pkg::WordBits-1:0] mem_wdata;
  logic [AW-1:0]                 mem_raddr;
  logic [opsc_pkg::WordBits-1:0] mem_rdata;
  logic [VW-1:0]                 alu_a;
  logic [VW-1:0]                 alu_b;
  logic [LimW-1:0]               alu_bound;
  logic [VW-1:0]                 alu_sum;
  logic                          alu_le;
  logic [opsc_pkg::CountW-1:0]   out_count;
  logic                          out_clamp;

  opsc_seq #(
    .MaxLimit(MaxLimit),
    .LimW    (LimW),
    .VW      (VW),
    .AW      (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_limit_i  (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_count_o (out_count),
    .out_clamp_o (out_clamp),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .alu_a_o     (alu_a),
    .alu_b_o     (alu_b),
    .alu_bound_o (alu_bound),
    .alu_sum_i   (alu_sum),
    .alu_le_i    (alu_le)
  );

  opsc_alu #(
    .LimW(LimW),
    .VW  (VW)
  ) u_alu (
    .op_a_i  (alu_a),
    .op_b_i  (alu_b),
    .bound_i (alu_bound),
    .sum_o   (alu_sum),
    .le_o    (alu_le)
  );

  opsc_bitmap #(
    .Words(Words),
    .AW   (AW)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tdata = opsc_pkg::OutTdataW'(out_count);
  assign m_axis_tuser = out_clamp;

endmodule

/* src/opsc_checker.sv */
`timescale 1ns / 1ps

module opsc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [opsc_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic [0:0]                     m_axis_tuser
);

  // The sequencer leaves idle as soon as it takes a limit.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still ready after accepting a beat");

  // A clamped limit becomes the built maximum, which holds primes when MaxLimit is at least 2.
  a_clamped_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[opsc_pkg::CountW-1:0] != '0)
    else $error("clamped result reports no primes");

  // Pad bits above the count stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[opsc_pkg::OutTdataW-1:opsc_pkg::CountW] == '0)
    else $error("output padding is not zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled output beat changed");

endmodule

bind odd_only_prime_sieve_counter_top opsc_checker u_opsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int SieveMax = opsc_pkg::MaxLimitDefault;
  localparam int SieveWords = SieveMax / 128 + 1;
  localparam int IdleLimit = 400000;
  localparam int NumDirected = 19;
  localparam int NumRandom = 100;

  typedef struct packed {
    logic [opsc_pkg::CountW-1:0] count;
    logic                        clamped;
  } sieve_result_t;

  typedef struct packed {
    logic [opsc_pkg::InW-1:0]    limit;
    logic                        typed;
    logic [opsc_pkg::CountW-1:0] count;
    logic                        clamped;
  } limit_row_t;

  // Rows marked typed carry a count known by hand; the rest go to the predictor.
  localparam limit_row_t DirectedRows [NumDirected] = '{
    '{16'd0,     1'b1, 13'd0,    1'b0},
    '{16'd1,     1'b1, 13'd0,    1'b0},
    '{16'd2,     1'b1, 13'd1,    1'b0},
    '{16'd3,     1'b1, 13'd2,    1'b0},
    '{16'd4,     1'b0, 13'd0,    1'b0},
    '{16'd5,     1'b1, 13'd3,    1'b0},
    '{16'd8,     1'b0, 13'd0,    1'b0},
    '{16'd9,     1'b0, 13'd0,    1'b0},
    '{16'd24,    1'b0, 13'd0,    1'b0},
    '{16'd25,    1'b0, 13'd0,    1'b0},
    '{16'd49,    1'b0, 13'd0,    1'b0},
    '{16'd121,   1'b0, 13'd0,    1'b0},
    '{16'd127,   1'b0, 13'd0,    1'b0},
    '{16'd128,   1'b0, 13'd0,    1'b0},
    '{16'd129,   1'b0, 13'd0,    1'b0},
    '{16'd1024,  1'b0, 13'd0,    1'b0},
    '{16'h5555,  1'b0, 13'd0,    1'b0},
    '{16'hAAAA,  1'b0, 13'd0,    1'b0},
    '{16'd65535, 1'b1, 13'd6542, 1'b0}
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [opsc_pkg::InW-1:0]       s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [opsc_pkg::OutTdataW-1:0] m_axis_tdata;
  logic [0:0]                     m_axis_tuser;

  sieve_result_t pending_counts [$];
  int            mismatch_count = 0;
  int            idle_cycles;

  odd_only_prime_sieve_counter_top #(
    .MaxLimit(SieveMax)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic sieve_result_t count_primes_upto(input logic [opsc_pkg::InW-1:0] lim_in);
    logic [opsc_pkg::WordBits-1:0] composite [SieveWords];
    longint unsigned               lim;
    longint unsigned               i;
    longint unsigned               j;
    longint unsigned               total;
    sieve_result_t                 res;
    foreach (composite[w]) composite[w] = '0;
    lim = lim_in;
    total = 0;
    res.clamped = 1'b0;
    if (lim > SieveMax) begin
      lim = SieveMax;
      res.clamped = 1'b1;
    end
    if (lim >= 2) begin
      total = 1;
      for (i = 3; i * i <= lim; i += 2) begin
        if (!composite[i >> 7][(i & 127) >> 1]) begin
          for (j = i * i; j <= lim; j += 2 * i) begin
            composite[j >> 7][(j & 127) >> 1] = 1'b1;
          end
        end
      end
      for (i = 3; i <= lim; i += 2) begin
        if (!composite[i >> 7][(i & 127) >> 1]) total++;
      end
    end
    if (total > opsc_pkg::CountMax) total = opsc_pkg::CountMax;
    res.count = total[opsc_pkg::CountW-1:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic logic [opsc_pkg::InW-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return opsc_pkg::InW'($urandom_range(0, 1023));
    if (r < 97) return opsc_pkg::InW'($urandom_range(1024, 8191));
    return opsc_pkg::InW'($urandom_range(0, opsc_pkg::InMax));
  endfunction

  function automatic void note_mismatch(input string what, input int exp_v, input int act_v);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected %0d, got %0d", $time, what, exp_v, act_v);
    end
  endfunction

  // Called and returns at a falling edge; leaves tvalid high on the accepted beat.
  task automatic send_limit(input logic [opsc_pkg::InW-1:0] lim, input logic typed,
                            input sieve_result_t typed_res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = opsc_pkg::InW'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = lim;
    do @(posedge clk_i); while (!s_axis_tready);
    if (typed) pending_counts.push_back(typed_res);
    else pending_counts.push_back(count_primes_upto(lim));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    do @(negedge clk_i); while (pending_counts.size() != 0);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(negedge clk_i);
      else repeat ($urandom_range(1, 20)) @(negedge clk_i);
      m_axis_tready = 1'b0;
      repeat (pick_gap()) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    sieve_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_counts.size() == 0) begin
        note_mismatch("beat with no pending result", 0, int'(m_axis_tdata));
      end else begin
        want = pending_counts.pop_front();
        if (m_axis_tdata !== opsc_pkg::OutTdataW'(want.count)) begin
          note_mismatch("prime_count", int'(want.count), int'(m_axis_tdata));
        end
        if (m_axis_tuser[0] !== want.clamped) begin
          note_mismatch("limit_clamped", int'(want.clamped), int'(m_axis_tuser[0]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("FAIL odd_only_prime_sieve_counter_top");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    limit_row_t    row;
    sieve_result_t typed_res;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NumDirected; r++) begin
      row = DirectedRows[r];
      typed_res.count   = row.count;
      typed_res.clamped = row.clamped;
      send_limit(row.limit, row.typed, typed_res);
    end
    drain_results();

    for (int n = 0; n < NumRandom; n++) begin
      if (n % 25 == 24) drain_results();
      send_limit(pick_limit(), 1'b0, '0);
    end
    drain_results();
    repeat (50) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS odd_only_prime_sieve_counter_top");
    end else begin
      $display("FAIL odd_only_prime_sieve_counter_top");
    end
    $finish;
  end

endmodule

/* odd_only_prime_sieve_counter_top.f */
src/opsc_pkg.sv
src/opsc_alu.sv
src/opsc_bitmap.sv
src/opsc_seq.sv
src/odd_only_prime_sieve_counter_top.sv
src/opsc_checker.sv
sim/tb.sv
